// ----- rtl/core/bss_pkg.sv -----
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and operation codes for the bounded search stack.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam int WORD_W  = 32;
  localparam int CAP_W   = 5;
  localparam int FIDX_W  = 4;
  localparam int COUNT_W = 5;

  typedef logic [2:0]               func_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam func_t FUNC_PUSH   = 3'd0;
  localparam func_t FUNC_POP    = 3'd1;
  localparam func_t FUNC_TOP    = 3'd2;
  localparam func_t FUNC_BOTTOM = 3'd3;
  localparam func_t FUNC_FIND   = 3'd4;
  localparam func_t FUNC_CLEAR  = 3'd5;

  typedef struct packed {
    func_t func;
    word_t value;
  } in_item_t;

  typedef struct packed {
    word_t              result_value;
    logic               ok;
    logic               found;
    logic [FIDX_W-1:0]  found_index;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
  } cfg_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic  push;
    logic  pop;
    word_t key;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/bss_chan_if.sv -----
// ----------------------------------------------------------------------------
// bss_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bss_cell.sv -----
// ----------------------------------------------------------------------------
// bss_cell
// One stack slot: shifts with push/pop, compares against the search key and
// forwards the search and bottom-read chain toward cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int OCC_W = 5
) (
  input  wire                      clk,
  input  wire bss_pkg::cell_ctl_t  ctl,
  input  wire [OCC_W-1:0]          occ,
  input  wire bss_pkg::word_t      push_in,
  input  wire bss_pkg::word_t      pop_in,
  input  wire                      hit_in,
  input  wire [IDX_W-1:0]          pos_in,
  input  wire bss_pkg::word_t      bot_in,
  output bss_pkg::word_t           data,
  output logic                     hit_out,
  output logic [IDX_W-1:0]         pos_out,
  output bss_pkg::word_t           bot_out
);
  import bss_pkg::*;

  localparam logic [OCC_W-1:0] MY_IDX  = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] MY_NEXT = OCC_W'(IDX + 1);

  word_t data_r;
  word_t data_nxt;
  logic  in_use;
  logic  is_bottom;

  // cell 0 is the top; the oldest word sits at occ-1
  assign in_use    = (MY_IDX < occ);
  assign is_bottom = (occ == MY_NEXT);

  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = push_in;
    end else if (ctl.pop) begin
      data_nxt = pop_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // highest in-use cell that matches is the lowest position from the bottom
  always_comb begin
    if (hit_in) begin
      hit_out = 1'b1;
      pos_out = pos_in;
    end else if (in_use && (data_r == ctl.key)) begin
      hit_out = 1'b1;
      pos_out = IDX_W'(IDX);
    end else begin
      hit_out = 1'b0;
      pos_out = pos_in;
    end
  end

  assign bot_out = is_bottom ? data_r : bot_in;
  assign data    = data_r;

endmodule

`default_nettype wire

// ----- rtl/core/bounded_stack_with_search_top.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// Bounded LIFO of signed 32-bit words with push, pop, top, bottom, find and
// clear, built as a shifting row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries {func, value}; one transfer per operation.
//   out_ch  carries {result_value, ok, found, found_index, count}; exactly
//           one result per accepted operation, in order.
//   cfg_ch  writes the capacity register; always ready, write only while
//           the stack is idle. Capacity above DEPTH acts as DEPTH.
// Output: the result is registered and shows on out_ch in the cycle after
//   the input transfer.
// Throughput: one operation per cycle unless out_ch stalls. Every cell shifts
//   and compares in the same cycle, and the find priority chain runs through
//   all DEPTH cells combinationally, so the clock period grows with DEPTH.
// Stall: the output register holds its result while out_ch.ready is low;
//   in_ch.ready drops until that result is taken.
// Reset: stack empty, capacity 16, no result pending. Word storage has no
//   reset and is never read before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_search_top #(
  parameter int DEPTH = 16
) (
  input  wire     clk,
  input  wire     rst_n,
  bss_chan_if.sink   in_ch,
  bss_chan_if.source out_ch,
  bss_chan_if.sink   cfg_ch
);
  import bss_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int PW    = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;
  localparam int CW    = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;
  localparam int KW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RST  = CAP_W'(16);

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  in_item_t  item;
  logic      accept;
  logic      room;
  logic      not_empty;
  cell_ctl_t ctl;

  word_t            data_c [DEPTH];
  logic             hit_c  [DEPTH+1];
  logic [IDX_W-1:0] pos_c  [DEPTH+1];
  word_t            bot_c  [DEPTH+1];

  logic [PW-1:0]    found_pos;
  logic [CW-1:0]    count_w;

  assign item      = in_ch.payload;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept    = in_ch.valid && in_ch.ready;
  assign not_empty = (occ_r != '0);
  assign room      = (KW'(occ_r) < KW'(cap_r)) && (occ_r != OCC_FULL);

  assign ctl.push = accept && (item.func == FUNC_PUSH) && room;
  assign ctl.pop  = accept && (item.func == FUNC_POP) && not_empty;
  assign ctl.key  = item.value;

  // chain enters at the far end with nothing found
  assign hit_c[DEPTH] = 1'b0;
  assign pos_c[DEPTH] = '0;
  assign bot_c[DEPTH] = '0;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    word_t push_src;
    word_t pop_src;
    if (j == 0) begin : g_first
      assign push_src = item.value;
    end else begin : g_mid
      assign push_src = data_c[j-1];
    end
    if (j == DEPTH - 1) begin : g_last
      assign pop_src = '0;
    end else begin : g_inner
      assign pop_src = data_c[j+1];
    end

    bss_cell #(
      .IDX   (j),
      .IDX_W (IDX_W),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (occ_r),
      .push_in (push_src),
      .pop_in  (pop_src),
      .hit_in  (hit_c[j+1]),
      .pos_in  (pos_c[j+1]),
      .bot_in  (bot_c[j+1]),
      .data    (data_c[j]),
      .hit_out (hit_c[j]),
      .pos_out (pos_c[j]),
      .bot_out (bot_c[j])
    );
  end

  // cell j holds position occ-1-j from the bottom
  assign found_pos = PW'(occ_r) - PW'(1) - PW'(pos_c[0]);

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.push) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (ctl.pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end else if (accept && (item.func == FUNC_CLEAR)) begin
      occ_nxt = '0;
    end
  end

  assign count_w = CW'(occ_nxt);

  always_comb begin
    out_item_nxt              = '0;
    out_item_nxt.count        = count_w[COUNT_W-1:0];
    case (item.func)
      FUNC_PUSH: begin
        out_item_nxt.ok = room;
      end
      FUNC_POP, FUNC_TOP: begin
        out_item_nxt.ok           = not_empty;
        out_item_nxt.result_value = not_empty ? data_c[0] : '0;
      end
      FUNC_BOTTOM: begin
        out_item_nxt.ok           = not_empty;
        out_item_nxt.result_value = not_empty ? bot_c[0] : '0;
      end
      FUNC_FIND: begin
        out_item_nxt.ok          = 1'b1;
        out_item_nxt.found       = hit_c[0];
        out_item_nxt.found_index = hit_c[0] ? found_pos[FIDX_W-1:0] : '0;
      end
      FUNC_CLEAR: begin
        out_item_nxt.ok = 1'b1;
      end
      default: begin
        out_item_nxt.ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign cap_nxt = cfg_ch.valid ? cfg_ch.payload.capacity : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cap_r       <= CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  // occupancy never passes the physical depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("occupancy above depth");

  // a successful push grows the stack by exactly one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> (occ_r == $past(occ_r) + OCC_W'(1)))
    else $error("push did not grow occupancy");

  // a failed operation never returns a word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.ok) |-> (out_item_r.result_value == '0))
    else $error("failed operation returned data");

  // every transfer in produces a pending result next cycle
  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted operation lost its result");

  // the reported count follows the occupancy register
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (CW'(out_item_r.count) == CW'(occ_r)) || (OCC_W > COUNT_W))
    else $error("count does not match occupancy");

endmodule

`default_nettype wire
